>>> sv/cpr_pkg.sv
// Shared types, constants and the sine table for the Clarke/Park round-trip unit.
// Used by cpr_mac, cpr_seq and clarke_park_round_trip_unit; depends on nothing else.
`default_nettype none
package cpr_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W = 16;
   localparam int TIME_W = 16;
   localparam int PERIOD_W = 32;
   localparam int STEP_W = 16;
   localparam int ACCUM_W = 33;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_STEP = 1'd1;
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 32'd10000;
   localparam logic [STEP_W-1:0] ANGLE_STEP_RST = 16'd393;

   // Multiply-accumulate operand and accumulator widths
   localparam int X_W = 18;
   localparam int Y_W = 17;
   localparam int PROD_W = X_W + Y_W;
   localparam int ACC_W = 36;

   // Transform coefficients
   localparam logic signed [Y_W-1:0] K_THIRD = 17'sd21845;
   localparam logic signed [Y_W-1:0] K_INV_SQRT3 = 17'sd37837;
   localparam logic signed [Y_W-1:0] K_HALF_SQRT3 = 17'sd56756;

   // Quarter-wave sine table
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int LOOKUP_W = ANGLE_W - 2 + IDX_W;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

   typedef logic [14:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Multiplier operand pairs
   typedef enum logic [3:0] {
      OP_DAD_K3,
      OP_DBC_KQ,
      OP_C_SD,
      OP_S_SQ,
      OP_C_SQ,
      OP_S_SD,
      OP_C_RD,
      OP_S_RQ,
      OP_S_RD,
      OP_C_RQ,
      OP_BQ_KS3
   } op_sel_type;

   // Accumulator base
   typedef enum logic [1:0] {
      BASE_ZERO,
      BASE_ACC,
      BASE_NEG_BD
   } base_sel_type;

   // Write-back target of the previous accumulator value
   typedef enum logic [3:0] {
      WB_NONE,
      WB_STAT_D,
      WB_STAT_Q,
      WB_ROT_D,
      WB_ROT_Q,
      WB_BACK_D,
      WB_BACK_Q,
      WB_OUT_B,
      WB_OUT_C
   } wb_sel_type;

   typedef struct packed {
      logic idle;
      logic accum;
      logic check;
      logic sincos;
      logic mac_en;
      op_sel_type op_sel;
      base_sel_type base_sel;
      logic sub;
      wb_sel_type wb_sel;
      logic out_load;
   } seq_ctrl_type;

   // Build the table by a Q30 Taylor series, round to Q1.15
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned e;
      longint sum;
      int k;
      int n;
      for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = longint'(k) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
         if (e > 32767) begin
            e = 32767;
         end
         rom[k] = 15'(e);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Sine of an angle from the quarter-wave table, no interpolation
   function automatic logic signed [SAMPLE_W-1:0] sine_of(input logic [ANGLE_W-1:0] ang);
      logic [1:0] quad;
      logic [LOOKUP_W-1:0] prod;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] idx_mirror;
      logic signed [SAMPLE_W-1:0] v;
      quad = ang[ANGLE_W-1 -: 2];
      prod = LOOKUP_W'(ang[ANGLE_W-3:0]) * LOOKUP_W'(SINE_TABLE_DEPTH);
      idx = IDX_W'(prod >> (ANGLE_W - 2));
      idx_mirror = IDX_W'(SINE_TABLE_DEPTH) - idx;
      v = quad[0] ? SAMPLE_W'({1'b0, SINE_ROM[idx_mirror]})
                  : SAMPLE_W'({1'b0, SINE_ROM[idx]});
      return quad[1] ? -v : v;
   endfunction

endpackage
`default_nettype wire

>>> sv/cpr_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation to Q1.15.
// Depends on cpr_pkg.
`default_nettype none
module cpr_mac (
   input  wire                                    clock,
   input  wire cpr_pkg::seq_ctrl_type             ctrl,
   input  wire logic signed [cpr_pkg::X_W-1:0]    x,
   input  wire logic signed [cpr_pkg::Y_W-1:0]    y,
   input  wire logic signed [cpr_pkg::ACC_W-1:0]  neg_bd,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]    res
);
   import cpr_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W:0] rounded;
   logic signed [ACC_W:0] shifted;
   logic shift16;
   logic fits;

   // Multiply and add to the selected base
   always_comb begin
      prod = x * y;
      prod_ext = ACC_W'(prod);
      case (ctrl.base_sel)
         BASE_ZERO:   base = '0;
         BASE_ACC:    base = acc_ff;
         BASE_NEG_BD: base = neg_bd;
         default:     base = '0;
      endcase
      acc_in = ctrl.sub ? (base - prod_ext) : (base + prod_ext);
   end

   // Hold the accumulator between steps
   always_ff @(posedge clock) begin
      if (ctrl.mac_en) begin
         acc_ff <= acc_in;
      end
   end

   // Round and saturate the held accumulator
   always_comb begin
      shift16 = (ctrl.wb_sel == WB_STAT_D) || (ctrl.wb_sel == WB_STAT_Q) ||
                (ctrl.wb_sel == WB_OUT_B) || (ctrl.wb_sel == WB_OUT_C);
      rounded = (ACC_W + 1)'(acc_ff) +
                (shift16 ? ((ACC_W + 1)'(1) <<< 15) : ((ACC_W + 1)'(1) <<< 14));
      shifted = shift16 ? (rounded >>> 16) : (rounded >>> 15);
      fits = (&shifted[ACC_W:SAMPLE_W-1]) || (~|shifted[ACC_W:SAMPLE_W-1]);
      if (fits) begin
         res = shifted[SAMPLE_W-1:0];
      end else if (shifted[ACC_W]) begin
         res = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end
   end

endmodule
`default_nettype wire

>>> sv/cpr_seq.sv
// Sequencer that steps one item through time check and the shared multiply schedule.
// Depends on cpr_pkg.
`default_nettype none
module cpr_seq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    trigger,
   input  wire                    out_free,
   output cpr_pkg::seq_ctrl_type  ctrl
);
   import cpr_pkg::*;

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_ACCUM = 20'h00002,
      ST_CHECK = 20'h00004,
      ST_SD    = 20'h00008,
      ST_SQ    = 20'h00010,
      ST_WSQ   = 20'h00020,
      ST_RD0   = 20'h00040,
      ST_RD1   = 20'h00080,
      ST_RQ0   = 20'h00100,
      ST_RQ1   = 20'h00200,
      ST_WRQ   = 20'h00400,
      ST_BD0   = 20'h00800,
      ST_BD1   = 20'h01000,
      ST_BQ0   = 20'h02000,
      ST_BQ1   = 20'h04000,
      ST_WBQ   = 20'h08000,
      ST_OB    = 20'h10000,
      ST_OC    = 20'h20000,
      ST_WOC   = 20'h40000,
      ST_DONE  = 20'h80000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Advance through the schedule
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and per-step controls
   always_comb begin
      state_in = state_ff;
      ctrl = '{idle: 1'b0, accum: 1'b0, check: 1'b0, sincos: 1'b0, mac_en: 1'b0,
               op_sel: OP_DAD_K3, base_sel: BASE_ZERO, sub: 1'b0, wb_sel: WB_NONE,
               out_load: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            ctrl.idle = 1'b1;
            if (req_valid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            ctrl.accum = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ctrl.check = 1'b1;
            state_in = trigger ? ST_SD : ST_DONE;
         end
         ST_SD: begin
            ctrl.sincos = 1'b1;
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_DAD_K3;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_DBC_KQ;
            ctrl.wb_sel = WB_STAT_D;
            state_in = ST_WSQ;
         end
         ST_WSQ: begin
            ctrl.wb_sel = WB_STAT_Q;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_C_SD;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_S_SQ;
            ctrl.base_sel = BASE_ACC;
            state_in = ST_RQ0;
         end
         ST_RQ0: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_C_SQ;
            ctrl.wb_sel = WB_ROT_D;
            state_in = ST_RQ1;
         end
         ST_RQ1: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_S_SD;
            ctrl.base_sel = BASE_ACC;
            ctrl.sub = 1'b1;
            state_in = ST_WRQ;
         end
         ST_WRQ: begin
            ctrl.wb_sel = WB_ROT_Q;
            state_in = ST_BD0;
         end
         ST_BD0: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_C_RD;
            state_in = ST_BD1;
         end
         ST_BD1: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_S_RQ;
            ctrl.base_sel = BASE_ACC;
            ctrl.sub = 1'b1;
            state_in = ST_BQ0;
         end
         ST_BQ0: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_S_RD;
            ctrl.wb_sel = WB_BACK_D;
            state_in = ST_BQ1;
         end
         ST_BQ1: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_C_RQ;
            ctrl.base_sel = BASE_ACC;
            state_in = ST_WBQ;
         end
         ST_WBQ: begin
            ctrl.wb_sel = WB_BACK_Q;
            state_in = ST_OB;
         end
         ST_OB: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_BQ_KS3;
            ctrl.base_sel = BASE_NEG_BD;
            state_in = ST_OC;
         end
         ST_OC: begin
            ctrl.mac_en = 1'b1;
            ctrl.op_sel = OP_BQ_KS3;
            ctrl.base_sel = BASE_NEG_BD;
            ctrl.sub = 1'b1;
            ctrl.wb_sel = WB_OUT_B;
            state_in = ST_WOC;
         end
         ST_WOC: begin
            ctrl.wb_sel = WB_OUT_C;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/clarke_park_round_trip_unit.sv
// Clarke/Park round-trip unit: time base, angle, operand selection and result words.
// Depends on cpr_pkg, cpr_seq and cpr_mac.
//
// Usage: the req channel takes one word of three Q1.15 phase samples and an elapsed
// time step; the rsp channel returns one word of ten fields for every req word.
// The time step is added to a saturating 33-bit accumulator. When it exceeds
// sample_period, the period is subtracted, the angle advances by angle_step and the
// Clarke, Park, inverse Park and inverse Clarke chain runs on one shared multiplier
// over 16 steps; otherwise the held results are returned again.
// A new req word is taken only after the previous one is done and its result is loaded;
// req_stall is high while a word is in work.
// The rsp word sits in an output register: a new req word is taken while it waits,
// and the next result waits in the sequencer until rsp_stall drops.
// Reset (synchronous) clears the accumulator, angle and held results and loads
// sample_period = 10000, angle_step = 393. csr writes take effect at once; write
// them only while the unit is idle.
`default_nettype none
module clarke_park_round_trip_unit (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         csr_wr_en,
   input  wire logic [cpr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [cpr_pkg::CSR_DATA_W-1:0]         csr_wr_data,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire logic signed [cpr_pkg::SAMPLE_W-1:0]    req_phase_a,
   input  wire logic signed [cpr_pkg::SAMPLE_W-1:0]    req_phase_b,
   input  wire logic signed [cpr_pkg::SAMPLE_W-1:0]    req_phase_c,
   input  wire logic [cpr_pkg::TIME_W-1:0]             req_time_step,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_stat_d,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_stat_q,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_rot_d,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_rot_q,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_back_d,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_back_q,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_out_a,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_out_b,
   output logic signed [cpr_pkg::SAMPLE_W-1:0]         rsp_out_c,
   output logic [cpr_pkg::ANGLE_W-1:0]                 rsp_angle
);
   import cpr_pkg::*;

   seq_ctrl_type ctrl;

   logic [PERIOD_W-1:0] period_ff;
   logic signed [STEP_W-1:0] step_ff;
   logic [TIME_W-1:0] ts_ff;
   logic signed [X_W-1:0] dad_ff;
   logic signed [X_W-1:0] dbc_ff;
   logic [ACCUM_W-1:0] ta_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic signed [SAMPLE_W-1:0] sin_ff;
   logic signed [SAMPLE_W-1:0] cos_ff;

   logic signed [SAMPLE_W-1:0] held_stat_d_ff;
   logic signed [SAMPLE_W-1:0] held_stat_q_ff;
   logic signed [SAMPLE_W-1:0] held_rot_d_ff;
   logic signed [SAMPLE_W-1:0] held_rot_q_ff;
   logic signed [SAMPLE_W-1:0] held_back_d_ff;
   logic signed [SAMPLE_W-1:0] held_back_q_ff;
   logic signed [SAMPLE_W-1:0] held_out_b_ff;
   logic signed [SAMPLE_W-1:0] held_out_c_ff;

   logic rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_stat_d_ff;
   logic signed [SAMPLE_W-1:0] rsp_stat_q_ff;
   logic signed [SAMPLE_W-1:0] rsp_rot_d_ff;
   logic signed [SAMPLE_W-1:0] rsp_rot_q_ff;
   logic signed [SAMPLE_W-1:0] rsp_back_d_ff;
   logic signed [SAMPLE_W-1:0] rsp_back_q_ff;
   logic signed [SAMPLE_W-1:0] rsp_out_b_ff;
   logic signed [SAMPLE_W-1:0] rsp_out_c_ff;
   logic [ANGLE_W-1:0] rsp_angle_ff;

   logic req_accept;
   logic rsp_accept;
   logic out_free;
   logic [ACCUM_W:0] ta_sum;
   logic [ACCUM_W:0] ta_diff;
   logic trigger;
   logic [ANGLE_W-1:0] step_ext;
   logic signed [X_W-1:0] dad_in;
   logic signed [X_W-1:0] dbc_in;
   logic signed [X_W-1:0] mac_x;
   logic signed [Y_W-1:0] mac_y;
   logic signed [ACC_W-1:0] neg_bd;
   logic signed [SAMPLE_W-1:0] mac_res;

   assign req_stall = ~ctrl.idle;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   cpr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .trigger   (trigger),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= SAMPLE_PERIOD_RST;
         step_ff <= ANGLE_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SAMPLE_PERIOD: period_ff <= csr_wr_data[PERIOD_W-1:0];
            REG_ANGLE_STEP:    step_ff <= csr_wr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the req word, pre-adding the Clarke differences
   always_comb begin
      dad_in = (X_W'(req_phase_a) <<< 1) - X_W'(req_phase_b) - X_W'(req_phase_c);
      dbc_in = X_W'(req_phase_b) - X_W'(req_phase_c);
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dad_ff <= dad_in;
         dbc_ff <= dbc_in;
         ts_ff <= req_time_step;
      end
   end

   // Time base: saturating add, then compare and subtract the period
   always_comb begin
      ta_sum = {1'b0, ta_ff} + (ACCUM_W + 1)'(ts_ff);
      ta_diff = {1'b0, ta_ff} - (ACCUM_W + 1)'(period_ff);
      trigger = ~ta_diff[ACCUM_W] & (|ta_diff[ACCUM_W-1:0]);
      step_ext = ANGLE_W'(step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= '0;
         angle_ff <= '0;
      end else if (ctrl.accum) begin
         ta_ff <= ta_sum[ACCUM_W] ? {ACCUM_W{1'b1}} : ta_sum[ACCUM_W-1:0];
      end else if (ctrl.check && trigger) begin
         ta_ff <= ta_diff[ACCUM_W-1:0];
         angle_ff <= angle_ff + step_ext;
      end
   end

   // Look up sine and cosine of the new angle
   always_ff @(posedge clock) begin
      if (ctrl.sincos) begin
         sin_ff <= sine_of(angle_ff);
         cos_ff <= sine_of(angle_ff + (ANGLE_W'(1) << (ANGLE_W - 2)));
      end
   end

   // Select the operand pair for the shared multiplier
   always_comb begin
      case (ctrl.op_sel)
         OP_DAD_K3: begin
            mac_x = dad_ff;
            mac_y = K_THIRD;
         end
         OP_DBC_KQ: begin
            mac_x = dbc_ff;
            mac_y = K_INV_SQRT3;
         end
         OP_C_SD: begin
            mac_x = X_W'(held_stat_d_ff);
            mac_y = Y_W'(cos_ff);
         end
         OP_S_SQ: begin
            mac_x = X_W'(held_stat_q_ff);
            mac_y = Y_W'(sin_ff);
         end
         OP_C_SQ: begin
            mac_x = X_W'(held_stat_q_ff);
            mac_y = Y_W'(cos_ff);
         end
         OP_S_SD: begin
            mac_x = X_W'(held_stat_d_ff);
            mac_y = Y_W'(sin_ff);
         end
         OP_C_RD: begin
            mac_x = X_W'(held_rot_d_ff);
            mac_y = Y_W'(cos_ff);
         end
         OP_S_RQ: begin
            mac_x = X_W'(held_rot_q_ff);
            mac_y = Y_W'(sin_ff);
         end
         OP_S_RD: begin
            mac_x = X_W'(held_rot_d_ff);
            mac_y = Y_W'(sin_ff);
         end
         OP_C_RQ: begin
            mac_x = X_W'(held_rot_q_ff);
            mac_y = Y_W'(cos_ff);
         end
         OP_BQ_KS3: begin
            mac_x = X_W'(held_back_q_ff);
            mac_y = K_HALF_SQRT3;
         end
         default: begin
            mac_x = '0;
            mac_y = '0;
         end
      endcase
      neg_bd = -(ACC_W'(held_back_d_ff) <<< 15);
   end

   cpr_mac u_mac (
      .clock  (clock),
      .ctrl   (ctrl),
      .x      (mac_x),
      .y      (mac_y),
      .neg_bd (neg_bd),
      .res    (mac_res)
   );

   // Write back rounded results into the held registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_stat_d_ff <= '0;
         held_stat_q_ff <= '0;
         held_rot_d_ff <= '0;
         held_rot_q_ff <= '0;
         held_back_d_ff <= '0;
         held_back_q_ff <= '0;
         held_out_b_ff <= '0;
         held_out_c_ff <= '0;
      end else begin
         case (ctrl.wb_sel)
            WB_STAT_D: held_stat_d_ff <= mac_res;
            WB_STAT_Q: held_stat_q_ff <= mac_res;
            WB_ROT_D:  held_rot_d_ff <= mac_res;
            WB_ROT_Q:  held_rot_q_ff <= mac_res;
            WB_BACK_D: held_back_d_ff <= mac_res;
            WB_BACK_Q: held_back_q_ff <= mac_res;
            WB_OUT_B:  held_out_b_ff <= mac_res;
            WB_OUT_C:  held_out_c_ff <= mac_res;
            default: begin
            end
         endcase
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_stat_d_ff <= held_stat_d_ff;
         rsp_stat_q_ff <= held_stat_q_ff;
         rsp_rot_d_ff <= held_rot_d_ff;
         rsp_rot_q_ff <= held_rot_q_ff;
         rsp_back_d_ff <= held_back_d_ff;
         rsp_back_q_ff <= held_back_q_ff;
         rsp_out_b_ff <= held_out_b_ff;
         rsp_out_c_ff <= held_out_c_ff;
         rsp_angle_ff <= angle_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_stat_d = rsp_stat_d_ff;
   assign rsp_stat_q = rsp_stat_q_ff;
   assign rsp_rot_d = rsp_rot_d_ff;
   assign rsp_rot_q = rsp_rot_q_ff;
   assign rsp_back_d = rsp_back_d_ff;
   assign rsp_back_q = rsp_back_q_ff;
   assign rsp_out_a = rsp_back_d_ff;
   assign rsp_out_b = rsp_out_b_ff;
   assign rsp_out_c = rsp_out_c_ff;
   assign rsp_angle = rsp_angle_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("unit still idle after taking a req word");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> out_free)
      else $error("result loaded over a waiting rsp word");

   a_angle_advance: assert property (@(posedge clock) disable iff (reset)
      ctrl.check && trigger |=> angle_ff == ANGLE_W'($past(angle_ff) + $past(step_ext)))
      else $error("angle did not advance by one step on a control sample");

   a_wb_follows_mac: assert property (@(posedge clock) disable iff (reset)
      ctrl.wb_sel != WB_NONE |-> $past(ctrl.mac_en))
      else $error("write-back without a preceding multiply step");

endmodule
`default_nettype wire
